### rtl/assert_macros.svh
// Assertion macros for the checker module of this project.
// Included by the files that assert; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is low.
`define CW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");

// Checked at every rising edge, during reset too.
`define CW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

### rtl/cwheel_pkg.sv
// Shared types, constants and helper functions of the color wheel shader.
// Used by every module of the block; depends on nothing.
package cwheel_pkg;

  // Grid geometry.
  localparam int COLUMNS = 10;
  localparam int ROWS    = 180;

  // Port field widths.
  localparam int PHASE_W = 16;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 8;
  localparam int LED_W   = 11;
  localparam int CH_W    = 8;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 40;

  // Internal datapath widths.
  localparam int COORD_W = 17;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ROOT_W  = COORD_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int CW      = 42;
  localparam int ANG_W   = 17;
  localparam int PRAD_W  = 16;
  localparam int PHI_W   = 15;
  localparam int HW_W    = 14;
  localparam int X_W     = 15;
  localparam int NUM_W   = 23;
  localparam int DEN_W   = 15;
  localparam int Q_W     = 8;

  // Angles in Q3.13 radians.
  localparam int Q_PI         = 25736;
  localparam int Q_TWO_PI     = 51472;
  localparam int Q_HALF_PI    = 12868;
  localparam int Q_THIRD      = 8579;
  localparam int Q_TWO_THIRDS = 17157;

  // CORDIC setup.
  localparam int CORDIC_STEPS    = 14;
  localparam int CORDIC_SCALE_SH = 16;
  localparam int CORDIC_LAT      = CORDIC_STEPS + 1;

  // Feather: atan(0.02 / r) taken as atan2(D, 50 * r) in grid units.
  localparam int FEATHER_MUL = 50;
  localparam int UNIT_D      = 2 * (COLUMNS - 1) * (ROWS - 1);

  // Color stage count: three setup stages, the divider, three output stages.
  localparam int COLOR_LAT = Q_W + 6;

  // Arctangent table in Q3.13, atan(2^-k).
  function automatic logic signed [ANG_W-1:0] atan_entry(input int k);
    logic signed [ANG_W-1:0] res;
    begin
      case (k)
        0:       res = ANG_W'(6434);
        1:       res = ANG_W'(3798);
        2:       res = ANG_W'(2007);
        3:       res = ANG_W'(1019);
        4:       res = ANG_W'(511);
        5:       res = ANG_W'(256);
        6:       res = ANG_W'(128);
        7:       res = ANG_W'(64);
        8:       res = ANG_W'(32);
        9:       res = ANG_W'(16);
        10:      res = ANG_W'(8);
        11:      res = ANG_W'(4);
        12:      res = ANG_W'(2);
        13:      res = ANG_W'(1);
        default: res = '0;
      endcase
      return res;
    end
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v, input int k);
    logic signed [CW-1:0] bias;
    begin
      bias = v[CW-1] ? ((CW'(1) <<< k) - CW'(1)) : '0;
      return (v + bias) >>> k;
    end
  endfunction

  // Sideband carried through the square root pipeline.
  typedef struct packed {
    logic signed [COORD_W-1:0] pp;
    logic signed [COORD_W-1:0] qq;
    logic [PRAD_W-1:0]         prad;
    logic [LED_W-1:0]          led;
  } sq_tag_t;

  // Sideband carried through the CORDIC pipeline.
  typedef struct packed {
    logic [PRAD_W-1:0] prad;
    logic [LED_W-1:0]  led;
  } cd_tag_t;

  // Which sector or border a pixel falls on.
  typedef enum logic [2:0] {
    K_BLUE,
    K_GREEN,
    K_RED,
    K_SEAM_GB,
    K_RG,
    K_BR,
    K_SEAM_BG
  } blend_kind_t;

  // One finished pixel.
  typedef struct packed {
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [LED_W-1:0] led;
  } pixel_t;

endpackage

### rtl/cwheel_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on cwheel_pkg.
module cwheel_sqrt import cwheel_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sq,
  input  sq_tag_t           in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sq_tag_t           out_tag
);

  logic [ROOT_W-1:0] vld;
  logic [REM_W-1:0]  rem       [ROOT_W];
  logic [REM_W-1:0]  rem_next  [ROOT_W];
  logic [ROOT_W-1:0] root      [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];
  logic [SQ_W-1:0]   val       [ROOT_W];
  logic [SQ_W-1:0]   val_next  [ROOT_W];
  sq_tag_t           tag       [ROOT_W];

  // Each stage brings down two radicand bits and settles one root bit.
  always_comb begin
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [SQ_W-1:0]   p_val;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  test;
    for (int s = 0; s < ROOT_W; s++) begin
      if (s == 0) begin
        p_rem  = '0;
        p_root = '0;
        p_val  = in_sq;
      end else begin
        p_rem  = rem[s-1];
        p_root = root[s-1];
        p_val  = val[s-1];
      end
      trial = {p_rem[REM_W-3:0], p_val[SQ_W-1:SQ_W-2]};
      test  = REM_W'({p_root, 2'b01});
      if (trial >= test) begin
        rem_next[s]  = trial - test;
        root_next[s] = {p_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[s]  = trial;
        root_next[s] = {p_root[ROOT_W-2:0], 1'b0};
      end
      val_next[s] = {p_val[SQ_W-3:0], 2'b00};
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[ROOT_W-2:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem    <= rem_next;
      root   <= root_next;
      val    <= val_next;
      tag[0] <= in_tag;
      for (int s = 1; s < ROOT_W; s++) begin
        tag[s] <= tag[s-1];
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_tag   = tag[ROOT_W-1];

endmodule

### rtl/cwheel_cordic.sv
// Two-lane pipelined vectoring CORDIC that returns atan2(y, x) in Q3.13.
// Depends on cwheel_pkg.
module cwheel_cordic import cwheel_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    in_x [2],
  input  logic signed [CW-1:0]    in_y [2],
  input  cd_tag_t                 in_tag,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_z [2],
  output cd_tag_t                 out_tag
);

  logic [CORDIC_STEPS:0]   vld;
  logic signed [CW-1:0]    xr     [2][CORDIC_STEPS+1];
  logic signed [CW-1:0]    yr     [2][CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] zr     [2][CORDIC_STEPS+1];
  logic signed [CW-1:0]    x_next [2][CORDIC_STEPS+1];
  logic signed [CW-1:0]    y_next [2][CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_next [2][CORDIC_STEPS+1];
  cd_tag_t                 tag    [CORDIC_STEPS+1];

  // Entry: scale up, fold the left half plane by a quarter turn; then the rotations.
  always_comb begin
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    for (int l = 0; l < 2; l++) begin
      xs = in_x[l] <<< CORDIC_SCALE_SH;
      ys = in_y[l] <<< CORDIC_SCALE_SH;
      if (xs < 0) begin
        if (ys >= 0) begin
          x_next[l][0] = ys;
          y_next[l][0] = -xs;
          z_next[l][0] = ANG_W'(Q_HALF_PI);
        end else begin
          x_next[l][0] = -ys;
          y_next[l][0] = xs;
          z_next[l][0] = -ANG_W'(Q_HALF_PI);
        end
      end else begin
        x_next[l][0] = xs;
        y_next[l][0] = ys;
        z_next[l][0] = '0;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        dx = shr_tz(xr[l][k], k);
        dy = shr_tz(yr[l][k], k);
        if (yr[l][k] > 0) begin
          x_next[l][k+1] = xr[l][k] + dy;
          y_next[l][k+1] = yr[l][k] - dx;
          z_next[l][k+1] = zr[l][k] + atan_entry(k);
        end else begin
          x_next[l][k+1] = xr[l][k] - dy;
          y_next[l][k+1] = yr[l][k] + dx;
          z_next[l][k+1] = zr[l][k] - atan_entry(k);
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[CORDIC_STEPS-1:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (ce) begin
      xr     <= x_next;
      yr     <= y_next;
      zr     <= z_next;
      tag[0] <= in_tag;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_z[0]  = zr[0][CORDIC_STEPS];
  assign out_z[1]  = zr[1][CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];

endmodule

### rtl/cwheel_color.sv
// Sector choice, border blend with a pipelined divider, and brightness scaling.
// Depends on cwheel_pkg.
module cwheel_color import cwheel_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_angle,
  input  logic signed [ANG_W-1:0] in_feather,
  input  cd_tag_t                 in_tag,
  input  logic [CH_W-1:0]         brightness,
  output logic                    out_valid,
  output pixel_t                  out_pix
);

  logic [COLOR_LAT-1:0] vld;

  // Stage 1 registers: wheel angle and clamped feather.
  logic [PHI_W-1:0] phi1;
  logic [HW_W-1:0]  hw1;
  logic [LED_W-1:0] led1;
  // Stage 2 registers: sector and blend position.
  blend_kind_t      kind2;
  logic [X_W-1:0]   x2;
  logic [HW_W-1:0]  hw2;
  logic [LED_W-1:0] led2;
  // Stage 3 registers: divider operands.
  blend_kind_t      kind3;
  logic [NUM_W-1:0] num3;
  logic [DEN_W-1:0] den3;
  logic [LED_W-1:0] led3;
  // Divider stages.
  logic [NUM_W-1:0] drem      [Q_W];
  logic [NUM_W-1:0] drem_next [Q_W];
  logic [Q_W-1:0]   dq        [Q_W];
  logic [Q_W-1:0]   dq_next   [Q_W];
  logic [DEN_W-1:0] dden      [Q_W];
  blend_kind_t      dkind     [Q_W];
  logic [LED_W-1:0] dled      [Q_W];
  // Output stages.
  logic [CH_W-1:0]  rm, gm, bm;
  logic [LED_W-1:0] ledm;
  logic [2*CH_W-1:0] rp, gp, bp;
  logic [LED_W-1:0] ledp;

  logic signed [ANG_W:0]   a_raw, a_w1, a_w2, a_w3;
  logic [HW_W-1:0]         hw_c;
  logic [PHI_W-1:0]        phi_c;
  blend_kind_t             kind_c;
  logic [X_W-1:0]          x_c;
  logic [CH_W-1:0]         t_c, r_c, g_c, b_c;

  // Stage 1: clamp the feather, wrap the rotated angle, halve it onto the wheel.
  always_comb begin
    if (in_feather < 0) begin
      hw_c = '0;
    end else if (in_feather > ANG_W'(Q_HALF_PI)) begin
      hw_c = HW_W'(Q_HALF_PI);
    end else begin
      hw_c = HW_W'(in_feather);
    end
    a_raw = (ANG_W+1)'(in_angle) - $signed({2'b00, in_tag.prad});
    a_w1  = (a_raw >= (ANG_W+1)'(Q_PI)) ? a_raw - (ANG_W+1)'(Q_TWO_PI) : a_raw;
    a_w2  = (a_w1 < -(ANG_W+1)'(Q_PI)) ? a_w1 + (ANG_W+1)'(Q_TWO_PI) : a_w1;
    a_w3  = (a_w2 < -(ANG_W+1)'(Q_PI)) ? a_w2 + (ANG_W+1)'(Q_TWO_PI) : a_w2;
    phi_c = PHI_W'((a_w3 + (ANG_W+1)'(Q_PI)) >>> 1);
  end

  // Stage 2: pick the sector or border, in priority order.
  always_comb begin
    logic signed [ANG_W-1:0] ph;
    logic signed [ANG_W-1:0] hw;
    ph = $signed({2'b00, phi1});
    hw = $signed({3'b000, hw1});
    kind_c = K_BLUE;
    x_c    = '0;
    if (ph > ANG_W'(Q_PI) - hw) begin
      kind_c = K_SEAM_GB;
      x_c    = X_W'(ph - (ANG_W'(Q_PI) - hw));
    end else if (ph > ANG_W'(Q_TWO_THIRDS) + hw) begin
      kind_c = K_GREEN;
    end else if (ph > ANG_W'(Q_TWO_THIRDS) - hw) begin
      kind_c = K_RG;
      x_c    = X_W'(ph - (ANG_W'(Q_TWO_THIRDS) - hw));
    end else if (ph > ANG_W'(Q_THIRD) + hw) begin
      kind_c = K_RED;
    end else if (ph > ANG_W'(Q_THIRD) - hw) begin
      kind_c = K_BR;
      x_c    = X_W'(ph - (ANG_W'(Q_THIRD) - hw));
    end else if (ph < hw) begin
      kind_c = K_SEAM_BG;
      x_c    = X_W'(hw - ph);
    end
  end

  // Divider: restoring, one quotient bit per stage, most significant first.
  always_comb begin
    logic [NUM_W-1:0] p_rem;
    logic [Q_W-1:0]   p_q;
    logic [DEN_W-1:0] p_den;
    logic [NUM_W-1:0] dsub;
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        p_rem = num3;
        p_q   = '0;
        p_den = den3;
      end else begin
        p_rem = drem[i-1];
        p_q   = dq[i-1];
        p_den = dden[i-1];
      end
      dsub = NUM_W'(p_den) << (Q_W - 1 - i);
      if (p_rem >= dsub) begin
        drem_next[i] = p_rem - dsub;
        dq_next[i]   = p_q | (Q_W'(1) << (Q_W - 1 - i));
      end else begin
        drem_next[i] = p_rem;
        dq_next[i]   = p_q;
      end
    end
  end

  // Map the target weight onto the channels; a zero width blend gives no weight.
  always_comb begin
    t_c = (dden[Q_W-1] == '0) ? '0 : dq[Q_W-1];
    r_c = '0;
    g_c = '0;
    b_c = '0;
    case (dkind[Q_W-1])
      K_SEAM_GB: begin
        g_c = 8'd255 - t_c;
        b_c = t_c;
      end
      K_GREEN:   g_c = 8'd255;
      K_RG: begin
        r_c = 8'd255 - t_c;
        g_c = t_c;
      end
      K_RED:     r_c = 8'd255;
      K_BR: begin
        r_c = t_c;
        b_c = 8'd255 - t_c;
      end
      K_SEAM_BG: begin
        g_c = t_c;
        b_c = 8'd255 - t_c;
      end
      default:   b_c = 8'd255;
    endcase
  end

  // Divide by 255 with rounding already in the operand.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
    logic [2*CH_W:0] p1;
    logic [2*CH_W:0] s;
    begin
      p1 = (2*CH_W+1)'(p) + 1'b1;
      s  = p1 + (p1 >> CH_W);
      return CH_W'(s >> CH_W);
    end
  endfunction

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[COLOR_LAT-2:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (ce) begin
      phi1  <= phi_c;
      hw1   <= hw_c;
      led1  <= in_tag.led;
      kind2 <= kind_c;
      x2    <= x_c;
      hw2   <= hw1;
      led2  <= led1;
      kind3 <= kind2;
      num3  <= (NUM_W'(x2) << 8) - NUM_W'(x2) + NUM_W'(hw2);
      den3  <= {hw2, 1'b0};
      led3  <= led2;
      drem  <= drem_next;
      dq    <= dq_next;
      dden[0]  <= den3;
      dkind[0] <= kind3;
      dled[0]  <= led3;
      for (int i = 1; i < Q_W; i++) begin
        dden[i]  <= dden[i-1];
        dkind[i] <= dkind[i-1];
        dled[i]  <= dled[i-1];
      end
      rm   <= r_c;
      gm   <= g_c;
      bm   <= b_c;
      ledm <= dled[Q_W-1];
      rp   <= rm * brightness + 16'd127;
      gp   <= gm * brightness + 16'd127;
      bp   <= bm * brightness + 16'd127;
      ledp <= ledm;
      out_pix.red   <= div255(rp);
      out_pix.green <= div255(gp);
      out_pix.blue  <= div255(bp);
      out_pix.led   <= ledp;
    end
  end

  assign out_valid = vld[COLOR_LAT-1];

endmodule

### rtl/rotating_color_wheel_shader.sv
// Top level of the rotating color wheel shader: input stage, squares,
// output buffer and brightness register. Depends on cwheel_pkg and submodules.
//
// Pixel shader for a serpentine LED grid: each transfer carries a phase, a
// column and a row, and yields the LED address and its RGB color. One pixel
// is taken per clock cycle; a pixel passes the input, square and sum
// registers, 17 square root stages, 15 CORDIC stages, 14 color stages, of
// which 8 are the blend divider, and the output buffer. A two-entry output
// buffer keeps input open while one result waits; input stalls only when
// both entries hold results. Brightness is to be written on the cfg channel
// only while idle; the block itself does not enforce this.
module rotating_color_wheel_shader import cwheel_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // rotation_phase[15:0], column[19:16], row[27:20]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // led_index[10:0], red[18:11], green[26:19], blue[34:27]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CH_W-1:0]  cfg_data
);

  logic ce;
  logic [CH_W-1:0] brightness;

  // Input stage.
  logic [PHASE_W-1:0] in_phase;
  logic [COL_W-1:0]   in_col;
  logic [ROW_W-1:0]   in_row;
  sq_tag_t            tag_c;
  logic               a_vld;
  sq_tag_t            a_tag;
  logic               b_vld;
  sq_tag_t            b_tag;
  logic [SQ_W-1:0]    b_pp2, b_qq2;
  logic               c_vld;
  sq_tag_t            c_tag;
  logic [SQ_W-1:0]    c_sum;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_tag_t           sq_tag;

  logic signed [CW-1:0]    cd_x [2];
  logic signed [CW-1:0]    cd_y [2];
  cd_tag_t                 cd_in_tag;
  logic                    cd_valid;
  logic signed [ANG_W-1:0] cd_z [2];
  cd_tag_t                 cd_tag;

  logic   col_valid;
  pixel_t col_pix;

  pixel_t     fifo_mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_phase = s_axis_tdata[PHASE_W-1:0];
  assign in_col   = s_axis_tdata[PHASE_W +: COL_W];
  assign in_row   = s_axis_tdata[PHASE_W+COL_W +: ROW_W];

  // Brightness register; the channel is always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 8'd255;
    end else if (cfg_valid) begin
      brightness <= cfg_data;
    end
  end

  // Centered coordinates, phase in radians and the serpentine address.
  always_comb begin
    int pp_i;
    int qq_i;
    logic [2*PHASE_W:0] prod;
    logic [LED_W-1:0]   pos;
    pp_i = (2 * int'(in_col) - (COLUMNS - 1)) * (ROWS - 1);
    qq_i = (2 * int'(in_row) - (ROWS - 1)) * (COLUMNS - 1);
    prod = (2*PHASE_W+1)'(in_phase) * (2*PHASE_W+1)'(Q_TWO_PI) + (2*PHASE_W+1)'(32768);
    pos  = in_col[0] ? LED_W'(ROWS - 1) - LED_W'(in_row) : LED_W'(in_row);
    tag_c.pp   = COORD_W'(pp_i);
    tag_c.qq   = COORD_W'(qq_i);
    tag_c.prad = PRAD_W'(prod >> 16);
    tag_c.led  = LED_W'(ROWS * int'(in_col)) + pos;
  end

  // Front stages: input, squares, sum of squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (ce) begin
      a_vld <= s_axis_tvalid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_tag <= tag_c;
      b_tag <= a_tag;
      b_pp2 <= SQ_W'(a_tag.pp) * SQ_W'(a_tag.pp);
      b_qq2 <= SQ_W'(a_tag.qq) * SQ_W'(a_tag.qq);
      c_tag <= b_tag;
      c_sum <= b_pp2 + b_qq2;
    end
  end

  cwheel_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (c_vld),
    .in_sq     (c_sum),
    .in_tag    (c_tag),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // Lane 0 gives the polar angle, lane 1 the feather width.
  assign cd_x[0] = CW'(sq_tag.pp);
  assign cd_y[0] = CW'(sq_tag.qq);
  assign cd_x[1] = CW'(sq_root) * CW'(FEATHER_MUL);
  assign cd_y[1] = CW'(UNIT_D);
  assign cd_in_tag.prad = sq_tag.prad;
  assign cd_in_tag.led  = sq_tag.led;

  cwheel_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sq_valid),
    .in_x      (cd_x),
    .in_y      (cd_y),
    .in_tag    (cd_in_tag),
    .out_valid (cd_valid),
    .out_z     (cd_z),
    .out_tag   (cd_tag)
  );

  cwheel_color u_color (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (cd_valid),
    .in_angle   (cd_z[0]),
    .in_feather (cd_z[1]),
    .in_tag     (cd_tag),
    .brightness (brightness),
    .out_valid  (col_valid),
    .out_pix    (col_pix)
  );

  // Two-entry output buffer; the pipeline moves while an entry is free.
  assign ce            = (cnt != 2'd2);
  assign s_axis_tready = ce;
  assign push          = col_valid & ce;
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = OUT_W'(fifo_mem[rp]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wp] <= col_pix;
    end
  end

endmodule

### rtl/cwheel_checker.sv
// Port-level checks for the color wheel shader, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cwheel_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A result held back by the sink stays put.
  `CW_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // Reset empties the output buffer.
  `CW_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid)

  // Input only closes when results are backed up at the output.
  `CW_ASSERT(a_stall_cause, clk, rst, !s_axis_tready |-> m_axis_tvalid)

  // The output only runs dry through a transfer.
  `CW_ASSERT(a_drain_by_transfer, clk, rst, ($fell(m_axis_tvalid) && !$past(rst)) |-> $past(m_axis_tready))

endmodule

bind rotating_color_wheel_shader cwheel_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
